// File: rtl/skt_pkg.sv
// Shared types and codes for the sorted key table.
package skt_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // What every cell of the row does on the current edge.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  // Per-cell control: shared operation plus the cell's own position flags.
  typedef struct packed {
    cell_op_t op;
    logic     occupied;   // index below the key count
    logic     at_or_above; // index at or above the request position
  } cell_ctrl_t;

endpackage

// File: rtl/skt_cell.sv
// One slot of the sorted row: holds a key and shifts it to or from its neighbors.
module skt_cell
  import skt_pkg::*;
#(
  parameter int KEY_WIDTH = 32
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic [KEY_WIDTH-1:0] new_key,
  input  logic [KEY_WIDTH-1:0] left_key,
  input  logic                 left_ge,
  input  logic [KEY_WIDTH-1:0] right_key,
  output logic [KEY_WIDTH-1:0] key_q,
  output logic                 ge
);

  logic [KEY_WIDTH-1:0] key_next;

  // Slot lies at or above the insertion point: empty, or holds a larger key.
  assign ge = !ctrl.occupied || ($signed(key_q) > $signed(new_key));

  always_comb begin
    key_next = key_q;
    case (ctrl.op)
      CELL_INSERT: begin
        if (ge) begin
          key_next = left_ge ? left_key : new_key;
        end
      end
      CELL_REMOVE: begin
        if (ctrl.at_or_above) begin
          key_next = right_key;
        end
      end
      default: key_next = key_q;
    endcase
  end

  always_ff @(posedge clk) begin
    key_q <= key_next;
  end

endmodule

// File: rtl/sorted_key_table_core.sv
// Sorted key table: a row of key cells kept in ascending signed order.
// Takes one request per clock unless the output stalls: insert, remove at
// index, read at index or clear. Every cell compares its key with the new
// key and shifts toward its neighbor in the same edge, so an insert or
// remove completes on that edge; the result is held in an output register,
// and a new request is taken while that register drains. Slots start
// undefined after reset and need no clearing pass; only the count and
// out_valid are reset. Insert into a full table reports ST_FULL, remove or read at an
// index not below the count reports ST_RANGE; neither changes the table.
module sorted_key_table_core
  import skt_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] key,
  input  logic [3:0]  position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_key,
  output logic [4:0]  stored_count,
  output logic [1:0]  status
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic                 in_accept;
  kind_t                kind_in;
  logic [KEY_WIDTH-1:0] new_key;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  status_t              status_next;
  cell_op_t             cell_op;
  logic [KEY_WIDTH-1:0] read_full;
  logic [31:0]          read_key_next;
  logic                 pos_bad;

  logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
  logic                 cell_ge  [CAPACITY];

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign kind_in   = kind_t'(kind);

  generate
    if (KEY_WIDTH > 32) begin : g_key_wide
      assign new_key = {{(KEY_WIDTH - 32){key[31]}}, key};
      assign read_key_next = (kind_in == KIND_READ && !pos_bad) ? read_full[31:0] : '0;
    end else if (KEY_WIDTH == 32) begin : g_key_same
      assign new_key = key;
      assign read_key_next = (kind_in == KIND_READ && !pos_bad) ? read_full : '0;
    end else begin : g_key_narrow
      assign new_key = key[KEY_WIDTH-1:0];
      // stored keys come back zero-extended to the output field
      assign read_key_next = (kind_in == KIND_READ && !pos_bad) ?
                             {{(32 - KEY_WIDTH){1'b0}}, read_full} : '0;
    end
  endgenerate

  assign pos_bad = int'(position) >= int'(count);

  // Request decode: status, count after the request, row operation.
  always_comb begin
    status_next = ST_DONE;
    count_next  = count;
    cell_op     = CELL_HOLD;
    unique case (kind_in)
      KIND_INSERT: begin
        if (int'(count) >= CAPACITY) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
          cell_op    = CELL_INSERT;
        end
      end
      KIND_REMOVE: begin
        if (pos_bad) begin
          status_next = ST_RANGE;
        end else begin
          count_next = count - CW'(1);
          cell_op    = CELL_REMOVE;
        end
      end
      KIND_READ: begin
        if (pos_bad) begin
          status_next = ST_RANGE;
        end
      end
      KIND_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  // Read select over the row, one-hot on the index.
  always_comb begin
    read_full = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == int'(position)) begin
        read_full = read_full | cell_key[i];
      end
    end
  end

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_ctrl_t           ctrl;
      logic [KEY_WIDTH-1:0] left_key;
      logic                 left_ge;
      logic [KEY_WIDTH-1:0] right_key;

      assign ctrl.op          = in_accept ? cell_op : CELL_HOLD;
      assign ctrl.occupied    = i < int'(count);
      assign ctrl.at_or_above = i >= int'(position);

      if (i == 0) begin : g_first
        assign left_key = new_key;
        assign left_ge  = 1'b0;
      end else begin : g_inner
        assign left_key = cell_key[i-1];
        assign left_ge  = cell_ge[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign right_key = cell_key[i];
      end else begin : g_body
        assign right_key = cell_key[i+1];
      end

      skt_cell #(
        .KEY_WIDTH(KEY_WIDTH)
      ) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .new_key  (new_key),
        .left_key (left_key),
        .left_ge  (left_ge),
        .right_key(right_key),
        .key_q    (cell_key[i]),
        .ge       (cell_ge[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      read_key     <= read_key_next;
      stored_count <= 5'(count_next);
      status       <= status_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= CAPACITY)
    else $error("key count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> int'(count) == CAPACITY)
    else $error("full status while table not full");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    in_accept && kind_in == KIND_INSERT && int'(count) < CAPACITY
    |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the table");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    in_accept && kind_in == KIND_CLEAR |=> count == '0 && stored_count == '0)
    else $error("clear left keys behind");

endmodule

// File: verif/sorted_key_table_core_tb.sv
// Self-checking testbench for the sorted key table core: random and directed requests.
`timescale 1ns / 1ps

module sorted_key_table_core_tb;
  import skt_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    kind_t              kind;
    logic signed [31:0] key;
    logic [3:0]         position;
  } request_t;

  typedef struct {
    logic [31:0] read_key;
    logic [4:0]  stored_count;
    status_t     status;
  } result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [31:0] key;
  logic [3:0]  position;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] read_key;
  logic [4:0]  stored_count;
  logic [1:0]  status;

  sorted_key_table_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .key(key), .position(position),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_key(read_key), .stored_count(stored_count), .status(status)
  );

  request_t req_queue[$];
  result_t  want_results[$];

  // predictor state
  logic signed [31:0] model_keys [CAPACITY];
  int                 model_count;

  int  idle_pct;
  int  stall_pct;
  int  gen_count;
  bit  gen_filling;
  bit  req_taken;
  int  cycles;
  int  requests_sent;
  int  results_checked;
  int  full_seen;
  int  range_seen;
  int  mismatches;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic result_t apply_table_op(request_t r);
    result_t res;
    int      slot;
    int      i;
    res.read_key     = '0;
    res.status       = ST_DONE;
    case (r.kind)
      KIND_INSERT: begin
        if (model_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // new key lands above any equal keys
          slot = 0;
          while (slot < model_count && model_keys[slot] <= r.key) slot++;
          for (i = model_count; i > slot; i--) model_keys[i] = model_keys[i - 1];
          model_keys[slot] = r.key;
          model_count++;
        end
      end
      KIND_REMOVE: begin
        if (int'(r.position) >= model_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = int'(r.position); i + 1 < model_count; i++)
            model_keys[i] = model_keys[i + 1];
          model_count--;
        end
      end
      KIND_READ: begin
        if (int'(r.position) >= model_count) res.status = ST_RANGE;
        else res.read_key = model_keys[r.position];
      end
      default: model_count = 0;
    endcase
    res.stored_count = model_count[4:0];
    return res;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, field, got, want);
    mismatches++;
  endtask

  // shadow of the count, so random positions mostly hit held entries
  task automatic queue_request(kind_t k, logic signed [31:0] kv, logic [3:0] p);
    request_t r;
    r.kind     = k;
    r.key      = kv;
    r.position = p;
    req_queue.push_back(r);
    case (k)
      KIND_INSERT: if (gen_count < CAPACITY) gen_count++;
      KIND_REMOVE: if (int'(p) < gen_count) gen_count--;
      KIND_CLEAR:  gen_count = 0;
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return $urandom;
    if (roll < 70) return $signed($urandom_range(8)) - 4;
    if (roll < 80) return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    if (roll < 90) return 32'sh7fffffff - $signed($urandom_range(3));
    return 32'sh80000000 + $signed($urandom_range(3));
  endfunction

  function automatic logic [3:0] pick_position();
    if (gen_count > 0 && $urandom_range(99) < 85) return 4'($urandom_range(gen_count - 1));
    return 4'($urandom_range(15));
  endfunction

  task automatic queue_random(int n);
    int roll;
    int left;
    left = n;
    while (left > 0) begin
      if (gen_count == CAPACITY) gen_filling = 1'b0;
      if (gen_count == 0) gen_filling = 1'b1;
      if ($urandom_range(99) < 2) gen_filling = ~gen_filling;
      roll = $urandom_range(99);
      if (roll < 2) begin
        queue_request(KIND_CLEAR, $urandom, 4'($urandom_range(15)));
      end else if (roll < 7) begin
        // noise: any field combination
        queue_request(kind_t'($urandom_range(3)), $urandom, 4'($urandom_range(15)));
      end else begin
        roll = $urandom_range(99);
        if (gen_filling ? roll < 60 : roll < 15)
          queue_request(KIND_INSERT, pick_key(), 4'($urandom_range(15)));
        else if (gen_filling ? roll < 80 : roll < 50)
          queue_request(KIND_READ, $urandom, pick_position());
        else
          queue_request(KIND_REMOVE, $urandom, pick_position());
      end
      left--;
    end
  endtask

  task automatic drain_all();
    while (req_queue.size() > 0 || in_valid || want_results.size() > 0) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (!in_valid || req_taken) begin
        if (req_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          kind     <= req_queue[0].kind;
          key      <= req_queue[0].key;
          position <= req_queue[0].position;
          void'(req_queue.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // request capture and prediction
  always @(posedge clk) begin
    request_t r;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        r.kind     = kind_t'(kind);
        r.key      = key;
        r.position = position;
        want_results.push_back(apply_table_op(r));
        requests_sent++;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (want_results.size() == 0) begin
        flag_mismatch("unexpected result count", 32'(stored_count), '0);
      end else begin
        w = want_results.pop_front();
        if (read_key !== w.read_key) flag_mismatch("read_key", read_key, w.read_key);
        if (stored_count !== w.stored_count)
          flag_mismatch("stored_count", 32'(stored_count), 32'(w.stored_count));
        if (status !== w.status) flag_mismatch("status", 32'(status), 32'(w.status));
        if (w.status == ST_FULL) full_seen++;
        if (w.status == ST_RANGE) range_seen++;
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, want_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int i;
    rst          = 1'b1;
    in_valid     = 1'b0;
    out_stall    = 1'b0;
    kind         = KIND_INSERT;
    key          = '0;
    position     = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    gen_count    = 0;
    gen_filling  = 1'b1;
    model_count  = 0;
    for (i = 0; i < CAPACITY; i++) model_keys[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty table, extremes, duplicates, range refusals, clear
    queue_request(KIND_READ, 32'sd0, 4'd0);
    queue_request(KIND_REMOVE, 32'sd0, 4'd15);
    queue_request(KIND_INSERT, 32'sh7fffffff, 4'd0);
    queue_request(KIND_INSERT, 32'sh80000000, 4'd15);
    queue_request(KIND_INSERT, 32'sd0, 4'd0);
    queue_request(KIND_INSERT, -32'sd1, 4'd0);
    queue_request(KIND_INSERT, 32'sd0, 4'd0);
    queue_request(KIND_INSERT, 32'sd1, 4'd0);
    queue_request(KIND_READ, 32'sd0, 4'd0);
    queue_request(KIND_READ, 32'sd0, 4'd5);
    queue_request(KIND_READ, 32'sd0, 4'd6);
    queue_request(KIND_REMOVE, 32'sd0, 4'd2);
    queue_request(KIND_READ, 32'sd0, 4'd2);
    queue_request(KIND_REMOVE, 32'sd0, 4'd4);
    queue_request(KIND_READ, 32'sd0, 4'd15);
    queue_request(KIND_CLEAR, 32'sh7fffffff, 4'd15);
    queue_request(KIND_READ, 32'sd0, 4'd0);
    queue_random(400);
    drain_all();

    idle_pct = 62;
    queue_random(400);
    drain_all();

    idle_pct  = 0;
    stall_pct = 62;
    queue_random(400);
    drain_all();

    idle_pct  = 18;
    stall_pct = 18;
    queue_random(400);
    drain_all();

    repeat (4) @(posedge clk);
    $display("%0d requests accepted, %0d results checked over four idle/stall mixes",
             requests_sent, results_checked);
    $display("refusals seen: %0d table full, %0d index out of range", full_seen, range_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/sorted_key_table_core.sv
verif/sorted_key_table_core_tb.sv
